[sv/vgc_pkg.sv]
package vgc_pkg;

    localparam int MAX_VOXELS = 256;
    localparam int COUNT_BITS = 20;
    localparam int IDX_W      = $clog2(MAX_VOXELS);
    localparam int USED_W     = IDX_W + 1;
    localparam int KEY_W      = 24;
    localparam int SUM_W      = 32 + COUNT_BITS;
    localparam int DIV_W      = SUM_W;
    localparam int DSR_W      = 32;
    localparam int EDGE_W     = 31;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    localparam logic [EDGE_W-1:0]     EDGE_MIN  = EDGE_W'(256);
    localparam logic [EDGE_W-1:0]     EDGE_RST  = EDGE_W'(65536);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic       OP_ADD   = 1'b0;
    localparam logic       OP_FETCH = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DROP  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] kx;
        logic signed [KEY_W-1:0] ky;
        logic signed [KEY_W-1:0] kz;
    } key_t;

    typedef struct packed {
        logic               is_fetch;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } item_t;

    typedef struct packed {
        key_t                    key;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sz;
        logic [COUNT_BITS-1:0]   cnt;
    } entry_t;

    function automatic logic key_less(input key_t a, input key_t b);
        logic r;
        if (a.kx != b.kx)
        begin
            r = (a.kx < b.kx);
        end
        else if (a.ky != b.ky)
        begin
            r = (a.ky < b.ky);
        end
        else
        begin
            r = (a.kz < b.kz);
        end
        return r;
    endfunction

endpackage

[sv/vgc_if.sv]
interface vgc_in_if;
    import vgc_pkg::*;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, output opcode, output point_x, output point_y,
                    output point_z, input ready);
    modport sink (input valid, input opcode, input point_x, input point_y,
                  input point_z, output ready);
endinterface

interface vgc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic signed [31:0] mean_z;
    logic               final_voxel;

    modport source (output valid, output status, output mean_x, output mean_y,
                    output mean_z, output final_voxel, input ready);
    modport sink (input valid, input status, input mean_x, input mean_y,
                  input mean_z, input final_voxel, output ready);
endinterface

[sv/vgc_front.sv]
module vgc_front
    import vgc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vgc_in_if.sink     pts,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    item_t      buf_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign pts.ready = (cnt_reg != 2'd2);
    assign push      = pts.valid && pts.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign pop       = q_pop && q_valid;
    assign q_item    = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= '{is_fetch: (pts.opcode == OP_FETCH),
                                     px: pts.point_x, py: pts.point_y,
                                     pz: pts.point_z};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[sv/vgc_div.sv]
module vgc_div
    import vgc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic             rem_nz
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DSR_W-1:0]     dsr_reg;
    logic [DSR_W:0]       trial;
    logic [DSR_W:0]       diff;
    logic                 bit_q;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign bit_q = (trial >= {1'b0, dsr_reg});

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = (rem_reg != '0);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= bit_q ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], bit_q};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[sv/vgc_back.sv]
module vgc_back
    import vgc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              edge_we,
    input  logic [EDGE_W-1:0] edge_wdata,
    input  logic              q_valid,
    input  item_t             q_item,
    output logic              q_pop,
    vgc_out_if.source         res
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_KDIV_START, ST_KDIV_WAIT, ST_ASCAN, ST_ARD, ST_ACMP,
        ST_FSCAN, ST_FRD, ST_FCMP, ST_BRD, ST_BLATCH, ST_MDIV_START, ST_MDIV_WAIT
    } state_t;

    state_t             state_reg;
    logic [EDGE_W-1:0]  edge_reg;
    item_t              item_reg;
    key_t               key_reg;
    logic [1:0]         axis_reg;
    logic [USED_W-1:0]  idx_reg;
    logic [USED_W-1:0]  used_reg;
    logic [USED_W-1:0]  emitted_reg;
    key_t               last_reg;
    logic               found_reg;
    logic               more_reg;
    logic [IDX_W-1:0]   best_reg;
    key_t               best_key_reg;
    entry_t             ent_reg;
    logic signed [31:0] mx_reg;
    logic signed [31:0] my_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic signed [31:0] out_mx_reg;
    logic signed [31:0] out_my_reg;
    logic signed [31:0] out_mz_reg;
    logic               out_final_reg;

    entry_t             mem [MAX_VOXELS];
    entry_t             rd_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;

    logic               div_start;
    logic [DIV_W-1:0]   div_a;
    logic [DSR_W-1:0]   div_b;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;
    logic               div_rnz;
    logic               neg;
    logic signed [SUM_W-1:0] sval;
    logic [EDGE_W-1:0]  edge_eff;
    logic [DIV_W-1:0]   qneg;
    logic [DIV_W-1:0]   qres;
    logic               key_hit;
    logic               skip;

    vgc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q),
        .rem_nz   (div_rnz)
    );

    assign edge_eff = (edge_reg < EDGE_MIN) ? EDGE_MIN : edge_reg;
    assign key_hit  = (rd_reg.key == key_reg);
    assign skip     = (emitted_reg != '0) && !key_less(last_reg, rd_reg.key);

    always_comb
    begin
        sval = '0;
        if (state_reg == ST_KDIV_START || state_reg == ST_KDIV_WAIT)
        begin
            case (axis_reg)
                2'd0:    sval = SUM_W'(item_reg.px);
                2'd1:    sval = SUM_W'(item_reg.py);
                default: sval = SUM_W'(item_reg.pz);
            endcase
            div_b = DSR_W'(edge_eff);
        end
        else
        begin
            case (axis_reg)
                2'd0:    sval = ent_reg.sx;
                2'd1:    sval = ent_reg.sy;
                default: sval = ent_reg.sz;
            endcase
            div_b = DSR_W'(ent_reg.cnt);
        end
        neg       = sval[SUM_W-1];
        div_a     = neg ? DIV_W'(-sval) : DIV_W'(sval);
        div_start = (state_reg == ST_KDIV_START) || (state_reg == ST_MDIV_START);
        qneg      = (div_rnz && state_reg == ST_KDIV_WAIT) ? ~div_q : (~div_q + 1'b1);
        qres      = neg ? qneg : div_q;
    end

    always_comb
    begin
        q_pop     = (state_reg == ST_IDLE) && q_valid && !out_valid_reg;
        mem_we    = 1'b0;
        mem_waddr = idx_reg[IDX_W-1:0];
        mem_wdata = rd_reg;
        if (state_reg == ST_ACMP && key_hit && rd_reg.cnt != COUNT_MAX)
        begin
            mem_we        = 1'b1;
            mem_wdata.sx  = rd_reg.sx + SUM_W'(item_reg.px);
            mem_wdata.sy  = rd_reg.sy + SUM_W'(item_reg.py);
            mem_wdata.sz  = rd_reg.sz + SUM_W'(item_reg.pz);
            mem_wdata.cnt = rd_reg.cnt + 1'b1;
        end
        else if (state_reg == ST_ASCAN && idx_reg == used_reg
                 && used_reg != USED_W'(MAX_VOXELS))
        begin
            mem_we    = 1'b1;
            mem_wdata = '{key: key_reg, sx: SUM_W'(item_reg.px),
                          sy: SUM_W'(item_reg.py), sz: SUM_W'(item_reg.pz),
                          cnt: COUNT_BITS'(1)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.mean_x      = out_mx_reg;
    assign res.mean_y      = out_my_reg;
    assign res.mean_z      = out_mz_reg;
    assign res.final_voxel = out_final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            edge_reg       <= EDGE_RST;
            used_reg       <= '0;
            emitted_reg    <= '0;
            last_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_mx_reg     <= '0;
            out_my_reg     <= '0;
            out_mz_reg     <= '0;
            out_final_reg  <= 1'b0;
            axis_reg       <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            more_reg       <= 1'b0;
            item_reg       <= '0;
            key_reg        <= '0;
            best_reg       <= '0;
            best_key_reg   <= '0;
            ent_reg        <= '0;
            mx_reg         <= '0;
            my_reg         <= '0;
        end
        else
        begin
            if (edge_we)
            begin
                edge_reg <= edge_wdata;
            end
            if (res.valid && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        item_reg  <= q_item;
                        axis_reg  <= '0;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        more_reg  <= 1'b0;
                        state_reg <= q_item.is_fetch ? ST_FSCAN : ST_KDIV_START;
                    end
                end
                ST_KDIV_START:
                begin
                    state_reg <= ST_KDIV_WAIT;
                end
                ST_KDIV_WAIT:
                begin
                    if (div_done)
                    begin
                        case (axis_reg)
                            2'd0:    key_reg.kx <= qres[KEY_W-1:0];
                            2'd1:    key_reg.ky <= qres[KEY_W-1:0];
                            default: key_reg.kz <= qres[KEY_W-1:0];
                        endcase
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= (axis_reg == 2'd2) ? ST_ASCAN : ST_KDIV_START;
                    end
                end
                ST_ASCAN:
                begin
                    if (idx_reg == used_reg)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_mx_reg     <= '0;
                        out_my_reg     <= '0;
                        out_mz_reg     <= '0;
                        out_final_reg  <= 1'b0;
                        if (used_reg == USED_W'(MAX_VOXELS))
                        begin
                            out_status_reg <= STATUS_DROP;
                        end
                        else
                        begin
                            out_status_reg <= STATUS_OK;
                            used_reg       <= used_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_ARD;
                    end
                end
                ST_ARD:
                begin
                    state_reg <= ST_ACMP;
                end
                ST_ACMP:
                begin
                    if (key_hit)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_mx_reg     <= '0;
                        out_my_reg     <= '0;
                        out_mz_reg     <= '0;
                        out_final_reg  <= 1'b0;
                        out_status_reg <= (rd_reg.cnt == COUNT_MAX) ? STATUS_DROP : STATUS_OK;
                        state_reg      <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_ASCAN;
                    end
                end
                ST_FSCAN:
                begin
                    if (idx_reg == used_reg)
                    begin
                        if (!found_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= STATUS_EMPTY;
                            out_mx_reg     <= '0;
                            out_my_reg     <= '0;
                            out_mz_reg     <= '0;
                            out_final_reg  <= 1'b0;
                            used_reg       <= '0;
                            emitted_reg    <= '0;
                            last_reg       <= '0;
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= USED_W'(best_reg);
                            state_reg <= ST_BRD;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_FRD;
                    end
                end
                ST_FRD:
                begin
                    state_reg <= ST_FCMP;
                end
                ST_FCMP:
                begin
                    if (!skip)
                    begin
                        if (!found_reg)
                        begin
                            found_reg    <= 1'b1;
                            best_reg     <= idx_reg[IDX_W-1:0];
                            best_key_reg <= rd_reg.key;
                        end
                        else
                        begin
                            more_reg <= 1'b1;
                            if (key_less(rd_reg.key, best_key_reg))
                            begin
                                best_reg     <= idx_reg[IDX_W-1:0];
                                best_key_reg <= rd_reg.key;
                            end
                        end
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= ST_FSCAN;
                end
                ST_BRD:
                begin
                    state_reg <= ST_BLATCH;
                end
                ST_BLATCH:
                begin
                    ent_reg   <= rd_reg;
                    axis_reg  <= '0;
                    state_reg <= ST_MDIV_START;
                end
                ST_MDIV_START:
                begin
                    state_reg <= ST_MDIV_WAIT;
                end
                ST_MDIV_WAIT:
                begin
                    if (div_done)
                    begin
                        axis_reg <= axis_reg + 1'b1;
                        case (axis_reg)
                            2'd0:
                            begin
                                mx_reg    <= qres[31:0];
                                state_reg <= ST_MDIV_START;
                            end
                            2'd1:
                            begin
                                my_reg    <= qres[31:0];
                                state_reg <= ST_MDIV_START;
                            end
                            default:
                            begin
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= STATUS_OK;
                                out_mx_reg     <= mx_reg;
                                out_my_reg     <= my_reg;
                                out_mz_reg     <= qres[31:0];
                                out_final_reg  <= !more_reg;
                                if (!more_reg)
                                begin
                                    used_reg    <= '0;
                                    emitted_reg <= '0;
                                    last_reg    <= '0;
                                end
                                else
                                begin
                                    last_reg    <= best_key_reg;
                                    emitted_reg <= emitted_reg + 1'b1;
                                end
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/voxel_grid_centroid_downsample_core.sv]
// channel  | dir | handshake         | payload
// pts      | in  | valid/ready       | opcode, point_x, point_y, point_z
// res      | out | valid/ready       | status, mean_x/y/z, final_voxel
// edge cfg | in  | voxel_edge_we     | voxel_edge_wdata (31 bits)
//
// add: the shared radix-2 divider computes the key of each axis in turn, then
//   a match scan walks the used table entries (up to 256 entries)
// fetch: a min-key search over the used entries, then a divider run per axis for the mean
// a 2-item input queue keeps pts ready while the back end works, until the queue is full; the result
//   register holds until taken, the back end waits for it to empty
// reset clears the used-entry count and sets the edge to 1.0; no memory clearing pass
module voxel_grid_centroid_downsample_core
    import vgc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              voxel_edge_we,
    input  logic [EDGE_W-1:0] voxel_edge_wdata,
    vgc_in_if.sink            pts,
    vgc_out_if.source         res
);

    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    vgc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .pts     (pts),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    vgc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_we    (voxel_edge_we),
        .edge_wdata (voxel_edge_wdata),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .res        (res)
    );

endmodule

[sv/vgc_checker.sv]
module vgc_checker
    import vgc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] mean_x,
    input logic [31:0] mean_y,
    input logic [31:0] mean_z,
    input logic        final_voxel
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_DROP
                       || status == STATUS_EMPTY))
        else $error("bad status");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |->
            mean_x == '0 && mean_y == '0 && mean_z == '0)
        else $error("nonzero centroid on failure");

    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_voxel |-> status == STATUS_OK)
        else $error("final flag on failure");

endmodule

bind voxel_grid_centroid_downsample_core vgc_checker u_vgc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .status      (res.status),
    .mean_x      (res.mean_x),
    .mean_y      (res.mean_y),
    .mean_z      (res.mean_z),
    .final_voxel (res.final_voxel)
);
